// ===== rtl/core/apf_pkg.sv =====
// Shared types and constants for the box pair overlap filter.
package apf_pkg;

    localparam int COORD_W   = 32;
    localparam int GROUP_W   = 8;
    localparam int IDX_OUT_W = 5;

    localparam logic [GROUP_W-1:0] GROUP_NONE = 8'd0;
    localparam logic [GROUP_W-1:0] GROUP_ONE  = 8'd1;

    typedef logic [IDX_OUT_W-1:0] out_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic [GROUP_W-1:0]        group_id;
        logic                      is_static;
        logic                      is_sphere;
    } box_t;

    localparam int BOX_W = $bits(box_t);

endpackage

// ===== rtl/core/apf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/apf_cmp.sv =====
// Pair test unit: group/static/sphere filter and inclusive three-axis overlap.
module apf_cmp (
    input  apf_pkg::box_t stored,
    input  apf_pkg::box_t incoming,
    output logic          hit
);

    logic filtered;
    logic overlap;

    always_comb
    begin
        filtered = ((stored.group_id != apf_pkg::GROUP_NONE)
                    && (stored.group_id == incoming.group_id))
                 || (stored.is_static && incoming.is_static)
                 || (stored.is_sphere && (incoming.group_id == apf_pkg::GROUP_ONE))
                 || (incoming.is_sphere && (stored.group_id == apf_pkg::GROUP_ONE));

        overlap = (stored.min_x <= incoming.max_x) && (incoming.min_x <= stored.max_x)
               && (stored.min_y <= incoming.max_y) && (incoming.min_y <= stored.max_y)
               && (stored.min_z <= incoming.max_z) && (incoming.min_z <= stored.max_z);

        hit = overlap && !filtered;
    end

endmodule

// ===== rtl/core/aabb_pair_overlap_filter.sv =====
// Top level: brute-force box pair filter with a sequencer over the box store.
//
// Usage: present a box on the input ports with start high; it is taken at a
// clock edge where start is high and busy is low. The box is compared against
// every box stored since the last new_set, one stored box per cycle through a
// single pair test unit fed by the store RAM, and is then written at the next
// index. Each overlapping, unfiltered pair appears on the result ports for one
// cycle with strobe high, in ascending earlier_index; last marks the final one.
// A box with no passing pair gives no result. When the store already holds
// MAX_BOXES boxes and new_set is low, the box is dropped and a single result
// with overflow and last high follows in the cycle after it is taken.
// Busy stays high while the sequencer walks its states: SCAN issues one RAM
// read per stored box, DRAIN covers the read latency and FIN writes the store;
// with an empty store or new_set high it goes straight to FIN. A pair leaves
// in the cycle after the next passing pair is compared; the final pair is
// sent from FIN, so the last result lands in the first idle cycle.
// The receiver cannot stall; results are never held.
// Reset empties the store (box count zero) and returns the sequencer to idle.
module aabb_pair_overlap_filter #(
    parameter int MAX_BOXES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                new_set,
    input  logic signed [apf_pkg::COORD_W-1:0]  min_x,
    input  logic signed [apf_pkg::COORD_W-1:0]  min_y,
    input  logic signed [apf_pkg::COORD_W-1:0]  min_z,
    input  logic signed [apf_pkg::COORD_W-1:0]  max_x,
    input  logic signed [apf_pkg::COORD_W-1:0]  max_y,
    input  logic signed [apf_pkg::COORD_W-1:0]  max_z,
    input  logic [apf_pkg::GROUP_W-1:0]         group_id,
    input  logic                                is_static,
    input  logic                                is_sphere,
    output logic                                strobe,
    output logic [apf_pkg::IDX_OUT_W-1:0]       earlier_index,
    output logic [apf_pkg::IDX_OUT_W-1:0]       later_index,
    output logic                                last,
    output logic                                overflow
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] box_count_reg, box_count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic              strobe_reg, strobe_next;
    apf_pkg::out_idx_t earlier_reg, earlier_next;
    apf_pkg::out_idx_t later_reg, later_next;
    logic              last_reg, last_next;
    logic              ovf_reg, ovf_next;

    apf_pkg::box_t box_reg;
    apf_pkg::box_t stored_box;
    logic [apf_pkg::BOX_W-1:0] ram_rdata;
    logic          load;
    logic          hit;
    logic          full;

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign earlier_index = earlier_reg;
    assign later_index   = later_reg;
    assign last          = last_reg;
    assign overflow      = ovf_reg;

    assign full       = !new_set && (box_count_reg == CNT_W'(MAX_BOXES));
    assign stored_box = apf_pkg::box_t'(ram_rdata);

    apf_ram #(
        .WIDTH (apf_pkg::BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (state_reg == ST_FIN),
        .waddr (idx_reg),
        .wdata (box_reg),
        .re    (state_reg == ST_SCAN),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    apf_cmp u_cmp (
        .stored   (stored_box),
        .incoming (box_reg),
        .hit      (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        box_count_next = box_count_reg;
        idx_next       = idx_reg;
        rd_addr_next   = rd_addr_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        strobe_next    = 1'b0;
        earlier_next   = earlier_reg;
        later_next     = later_reg;
        last_next      = 1'b0;
        ovf_next       = 1'b0;
        load           = 1'b0;

        // Hold each hit back in a pending slot so the final one can carry last.
        if (cmp_vld_reg && hit)
        begin
            if (pend_vld_reg)
            begin
                strobe_next  = 1'b1;
                earlier_next = apf_pkg::out_idx_t'(pend_idx_reg);
                later_next   = apf_pkg::out_idx_t'(idx_reg);
            end
            pend_vld_next = 1'b1;
            pend_idx_next = cmp_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (full)
                    begin
                        // Drop the item; store stays as it is.
                        strobe_next  = 1'b1;
                        earlier_next = '0;
                        later_next   = '0;
                        last_next    = 1'b1;
                        ovf_next     = 1'b1;
                    end
                    else
                    begin
                        load          = 1'b1;
                        pend_vld_next = 1'b0;
                        rd_addr_next  = '0;
                        idx_next      = new_set ? '0 : box_count_reg[IDX_W-1:0];
                        if (new_set || (box_count_reg == '0))
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_addr_reg;
                rd_addr_next = rd_addr_reg + IDX_W'(1);
                if (rd_addr_reg == (idx_reg - IDX_W'(1)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (pend_vld_reg)
                begin
                    strobe_next  = 1'b1;
                    earlier_next = apf_pkg::out_idx_t'(pend_idx_reg);
                    later_next   = apf_pkg::out_idx_t'(idx_reg);
                    last_next    = 1'b1;
                end
                pend_vld_next  = 1'b0;
                box_count_next = CNT_W'(idx_reg) + CNT_W'(1);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            box_count_reg <= '0;
            idx_reg       <= '0;
            rd_addr_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            strobe_reg    <= 1'b0;
            earlier_reg   <= '0;
            later_reg     <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            idx_reg       <= idx_next;
            rd_addr_reg   <= rd_addr_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            pend_vld_reg  <= pend_vld_next;
            pend_idx_reg  <= pend_idx_next;
            strobe_reg    <= strobe_next;
            earlier_reg   <= earlier_next;
            later_reg     <= later_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            box_reg.min_x     <= min_x;
            box_reg.min_y     <= min_y;
            box_reg.min_z     <= min_z;
            box_reg.max_x     <= max_x;
            box_reg.max_y     <= max_y;
            box_reg.max_z     <= max_z;
            box_reg.group_id  <= group_id;
            box_reg.is_static <= is_static;
            box_reg.is_sphere <= is_sphere;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        box_count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count exceeds store depth");

    a_cmp_below_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (cmp_idx_reg < idx_reg))
        else $error("compare index not below incoming index");

    a_accept_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || (strobe && overflow)))
        else $error("accepted item neither scanned nor rejected");

    a_ovf_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && overflow) |-> (last && !busy && (box_count_reg == CNT_W'(MAX_BOXES))))
        else $error("overflow result without a full store");
`endif

endmodule
